### hw/rtl/awbb_pkg.sv
package awbb_pkg;

  localparam int MaxWindow = 64;
  localparam int WinIdxW   = $clog2(MaxWindow);
  localparam int AlphaSumW = 14;
  localparam int ColorSumW = 22;
  localparam int DivW      = 22;

  localparam logic [0:0] RegWindowSize = 1'd0;
  localparam logic [0:0] RegAlphaOnly  = 1'd1;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch input pixel
    logic drain;     // use zero pixel
    logic evict;     // read leaving pixel
    logic update;    // apply sums
    logic div_start; // start quotients
    logic clear;     // end of row
  } awbb_cmd_t;

  typedef struct packed {
    logic div_done;
  } awbb_sts_t;

endpackage

### hw/rtl/awbb_div.sv
// Restoring divider, one quotient bit per cycle, saturates at 255.
module awbb_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [awbb_pkg::DivW-1:0] num,
  input  logic [awbb_pkg::DivW-1:0] den,
  output logic                      done,
  output logic [7:0]                quot
);
  localparam int CntW = $clog2(awbb_pkg::DivW + 1);

  logic [awbb_pkg::DivW-1:0] rem;
  logic [awbb_pkg::DivW-1:0] q;
  logic [awbb_pkg::DivW-1:0] dv;
  logic [CntW-1:0]           cnt;
  logic                      busy;
  logic [awbb_pkg::DivW:0]   trial;

  always_comb begin
    trial = {rem, q[awbb_pkg::DivW-1]} - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      q    <= num;
      dv   <= den;
      cnt  <= CntW'(awbb_pkg::DivW);
    end else if (busy) begin
      if (!trial[awbb_pkg::DivW]) begin
        rem <= trial[awbb_pkg::DivW-1:0];
        q   <= {q[awbb_pkg::DivW-2:0], 1'b1};
      end else begin
        rem <= {rem[awbb_pkg::DivW-2:0], q[awbb_pkg::DivW-1]};
        q   <= {q[awbb_pkg::DivW-2:0], 1'b0};
      end
      cnt <= cnt - CntW'(1);
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quot = (q[awbb_pkg::DivW-1:8] != '0) ? 8'hFF : q[7:0];
endmodule

### hw/rtl/awbb_datapath.sv
module awbb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  awbb_pkg::awbb_cmd_t           cmd,
  output awbb_pkg::awbb_sts_t           sts,
  input  logic [31:0]                   pix_in,
  input  logic [6:0]                    win,
  input  logic                          alpha_only,
  output logic [31:0]                   result
);
  logic [31:0] mem [awbb_pkg::MaxWindow];
  logic [31:0] old_pix;
  logic [31:0] cur;
  logic [awbb_pkg::WinIdxW-1:0] head;
  logic [7:0]  pos;
  logic [awbb_pkg::AlphaSumW-1:0] asum;
  logic [awbb_pkg::ColorSumW-1:0] rsum, gsum, bsum;
  logic        use_old;
  logic        evict_due;
  logic [15:0] pr, pg, pb, orr, og, ob;
  logic [awbb_pkg::WinIdxW-1:0] slot;
  logic [3:0]  dd;
  logic [7:0]  qa, qr, qg, qb;

  assign slot = head - win[awbb_pkg::WinIdxW-1:0];
  assign evict_due = {1'b0, pos} >= {2'b0, win};

  always_ff @(posedge clk) begin
    if (cmd.evict) old_pix <= mem[slot];
    if (cmd.load) cur <= cmd.drain ? 32'd0 : pix_in;
    if (cmd.update) mem[head] <= cur;
  end

  // registered products
  always_ff @(posedge clk) begin
    pr <= {8'd0, cur[23:16]} * {8'd0, cur[31:24]};
    pg <= {8'd0, cur[15:8]} * {8'd0, cur[31:24]};
    pb <= {8'd0, cur[7:0]} * {8'd0, cur[31:24]};
    orr <= use_old ? {8'd0, old_pix[23:16]} * {8'd0, old_pix[31:24]} : 16'd0;
    og  <= use_old ? {8'd0, old_pix[15:8]} * {8'd0, old_pix[31:24]} : 16'd0;
    ob  <= use_old ? {8'd0, old_pix[7:0]} * {8'd0, old_pix[31:24]} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; pos <= '0; asum <= '0; rsum <= '0; gsum <= '0; bsum <= '0;
      use_old <= 1'b0;
    end else begin
      if (cmd.load) use_old <= evict_due;
      if (cmd.update) begin
        head <= head + {{(awbb_pkg::WinIdxW-1){1'b0}}, 1'b1};
        if (pos != 8'hFF) pos <= pos + 8'd1;
        asum <= asum + {6'd0, cur[31:24]}
              - (use_old ? {6'd0, old_pix[31:24]} : '0);
        rsum <= rsum + 22'(pr) - 22'(orr);
        gsum <= gsum + 22'(pg) - 22'(og);
        bsum <= bsum + 22'(pb) - 22'(ob);
      end
      if (cmd.clear) begin
        pos <= '0; asum <= '0; rsum <= '0; gsum <= '0; bsum <= '0;
      end
    end
  end

  awbb_div u_da (.clk, .rst, .start(cmd.div_start), .num(22'(asum)),
    .den(22'(win)), .done(dd[0]), .quot(qa));
  awbb_div u_dr (.clk, .rst, .start(cmd.div_start), .num(rsum),
    .den(22'(asum)), .done(dd[1]), .quot(qr));
  awbb_div u_dg (.clk, .rst, .start(cmd.div_start), .num(gsum),
    .den(22'(asum)), .done(dd[2]), .quot(qg));
  awbb_div u_db (.clk, .rst, .start(cmd.div_start), .num(bsum),
    .den(22'(asum)), .done(dd[3]), .quot(qb));

  assign sts.div_done = &dd;

  always_comb begin
    if (asum == '0) result = '0;
    else if (alpha_only) result = {qa, 24'd0};
    else result = {qa, qr, qg, qb};
  end
endmodule

### hw/rtl/awbb_ctrl.sv
module awbb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                in_last,
  input  logic [6:0]          win,
  input  logic                out_free,
  input  awbb_pkg::awbb_sts_t sts,
  output awbb_pkg::awbb_cmd_t cmd,
  output logic                idle,
  output logic                emit,
  output logic                emit_last
);
  typedef enum logic [2:0] {
    S_IDLE, S_EVICT, S_MUL, S_UPD, S_DSTART, S_DIV, S_EMIT
  } state_t;

  state_t     state;
  logic       last;
  logic [6:0] left;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; last <= 1'b0; left <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_fire) begin
          state <= S_EVICT;
          last  <= in_last;
          left  <= in_last ? win - 7'd1 : 7'd0;
        end
        S_EVICT:  state <= S_MUL;
        S_MUL:    state <= S_UPD;
        S_UPD:    state <= S_DSTART;
        S_DSTART: state <= S_DIV;
        S_DIV:    if (sts.div_done) state <= S_EMIT;
        S_EMIT: if (out_free) begin
          if (left != 7'd0) begin
            left  <= left - 7'd1;
            state <= S_EVICT;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    idle = (state == S_IDLE);
    emit = (state == S_EMIT) && out_free;
    emit_last = last && (left == 7'd0);
    cmd.load  = in_fire || (emit && left != 7'd0);
    cmd.drain = !in_fire;
    cmd.evict = in_fire || (emit && left != 7'd0);
    cmd.update = (state == S_UPD);
    // dividers sample the sums once they have settled
    cmd.div_start = (state == S_DSTART);
    cmd.clear = emit && emit_last;
  end
endmodule

### hw/rtl/alpha_weighted_box_blur_row.sv
// Each input passes through evict read, product register, sum update,
// divider start and a bit-serial divide before its output is valid.
// One item in flight: the next input is taken only once the last result is
// emitted; on row end each of the window-1 drain outputs follows the one before.
// Reset (synchronous rst): sums and position clear, window 1, alpha_only 0;
// window pixel store is not cleared.
module alpha_weighted_box_blur_row (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // in_alpha, in_red, in_green, in_blue
  input  logic        s_tlast,  // row_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // out_alpha, out_red, out_green, out_blue
  output logic        m_tlast   // row_done
);
  logic [6:0] window_size;
  logic       alpha_only;
  logic [6:0] win;
  logic       idle, emit, emit_last, in_fire;
  logic [31:0] pix, res;
  awbb_pkg::awbb_cmd_t cmd;
  awbb_pkg::awbb_sts_t sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= 7'd1; alpha_only <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        awbb_pkg::RegWindowSize: window_size <= cfg_data;
        awbb_pkg::RegAlphaOnly:  alpha_only  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign win = (window_size == 7'd0) ? 7'd1
             : (window_size > 7'(awbb_pkg::MaxWindow)) ? 7'(awbb_pkg::MaxWindow)
             : window_size;

  assign s_tready = idle;
  assign in_fire = s_tvalid && s_tready;
  // model packs A,R,G,B high to low; tdata has alpha lowest
  assign pix = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};

  awbb_ctrl u_ctrl (.clk, .rst, .in_fire, .in_last(s_tlast), .win,
    .out_free(!m_tvalid || m_tready), .sts, .cmd, .idle, .emit, .emit_last);

  awbb_datapath u_dp (.clk, .rst, .cmd, .sts, .pix_in(pix), .win, .alpha_only,
    .result(res));

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (emit) begin
      m_tdata <= {res[7:0], res[15:8], res[23:16], res[31:24]};
      m_tlast <= emit_last;
    end
  end
endmodule

### bench/alpha_weighted_box_blur_row_tb.sv
`timescale 1ns / 1ps

module alpha_weighted_box_blur_row_tb;

  typedef struct packed {
    logic       last;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] a;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // in_alpha, in_red, in_green, in_blue
  logic        s_tlast;   // row_end
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // out_alpha, out_red, out_green, out_blue
  logic        m_tlast;   // row_done

  alpha_weighted_box_blur_row uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  pixel_t tx_q[$];
  pixel_t blurred_q[$];
  int     errors;
  int     tx_gap;
  int     rx_gap;
  logic   long_hold;
  logic   calm;

  // predictor state
  logic [6:0]  win_reg;
  logic        aonly_reg;
  logic [31:0] row_px[awbb_pkg::MaxWindow];
  logic [13:0] asum;
  logic [21:0] rsum, gsum, bsum;
  logic [7:0]  pos;
  int          head;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [7:0] sat_quot(input int unsigned num, input int unsigned den);
    int unsigned q;
    q = num / den;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic logic [21:0] wprod(input logic [7:0] c, input logic [7:0] al);
    return {14'd0, c} * {14'd0, al};
  endfunction

  task automatic slide_window(input logic [7:0] a, r, g, b, input logic done, input int win);
    pixel_t o;
    logic [31:0] p;
    if (int'(pos) >= win) begin
      p = row_px[(head + awbb_pkg::MaxWindow - win) % awbb_pkg::MaxWindow];
      asum = asum - {6'd0, p[31:24]};
      rsum = rsum - wprod(p[23:16], p[31:24]);
      gsum = gsum - wprod(p[15:8], p[31:24]);
      bsum = bsum - wprod(p[7:0], p[31:24]);
    end
    row_px[head] = {a, r, g, b};
    head = (head + 1) % awbb_pkg::MaxWindow;
    asum = asum + {6'd0, a};
    rsum = rsum + wprod(r, a);
    gsum = gsum + wprod(g, a);
    bsum = bsum + wprod(b, a);
    if (pos < 8'd255) pos++;
    o = '0;
    if (asum != 0) begin
      o.a = sat_quot(32'(asum), win);
      if (!aonly_reg) begin
        o.r = sat_quot(32'(rsum), 32'(asum));
        o.g = sat_quot(32'(gsum), 32'(asum));
        o.b = sat_quot(32'(bsum), 32'(asum));
      end
    end
    o.last = done;
    blurred_q = {blurred_q, o};
  endtask

  task automatic blur_predict(input pixel_t px);
    int win;
    win = (win_reg == 0) ? 1
        : (win_reg > awbb_pkg::MaxWindow) ? awbb_pkg::MaxWindow : int'(win_reg);
    slide_window(px.a, px.r, px.g, px.b, px.last && win == 1, win);
    if (px.last) begin
      for (int k = 1; k < win; k++)
        slide_window(8'd0, 8'd0, 8'd0, 8'd0, k + 1 == win, win);
      asum = 0;
      rsum = 0;
      gsum = 0;
      bsum = 0;
      pos = 0;
    end
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      s_tvalid <= 0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) blur_predict({s_tlast, s_tdata});
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 0;
        end else if (tx_q.size() > 0) begin
          px = tx_q.pop_front();
          s_tdata <= px[31:0];
          s_tlast <= px.last;
          s_tvalid <= 1;
          if (!calm && $urandom % 4 == 0) tx_gap <= $urandom_range(1, 19);
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      rx_gap <= 0;
    end else if (long_hold) begin
      m_tready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (!calm && $urandom % 6 == 0) rx_gap <= $urandom_range(1, 19);
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (blurred_q.size() == 0) begin
        note_mismatch($sformatf("unexpected transaction data=%h last=%b", m_tdata, m_tlast));
      end else begin
        want = blurred_q.pop_front();
        if (m_tdata[7:0] !== want.a)
          note_mismatch($sformatf("out_alpha %h want %h", m_tdata[7:0], want.a));
        if (m_tdata[15:8] !== want.r)
          note_mismatch($sformatf("out_red %h want %h", m_tdata[15:8], want.r));
        if (m_tdata[23:16] !== want.g)
          note_mismatch($sformatf("out_green %h want %h", m_tdata[23:16], want.g));
        if (m_tdata[31:24] !== want.b)
          note_mismatch($sformatf("out_blue %h want %h", m_tdata[31:24], want.b));
        if (m_tlast !== want.last)
          note_mismatch($sformatf("row_done %b want %b", m_tlast, want.last));
      end
    end
  end

  task automatic push_px(input logic [7:0] a, r, g, b, input logic last);
    pixel_t px;
    px = {last, b, g, r, a};
    tx_q = {tx_q, px};
  endtask

  task automatic push_rand_px(input logic last);
    logic [7:0] a;
    case ($urandom % 6)
      0: a = 8'd0;
      1: a = 8'd255;
      default: a = 8'($urandom);
    endcase
    push_px(a, 8'($urandom), 8'($urandom), 8'($urandom), last);
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (tx_q.size() != 0 || s_tvalid || blurred_q.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == awbb_pkg::RegWindowSize) win_reg = val;
    else aonly_reg = val[0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_row;
    int len;
    write_reg(awbb_pkg::RegWindowSize,
              ($urandom % 8 == 0) ? 7'd64 : 7'($urandom_range(1, 8)));
    write_reg(awbb_pkg::RegAlphaOnly, 7'($urandom % 3 == 0));
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) push_rand_px(i == len - 1);
    wait_drained();
  endtask

  initial begin
    int sent;
    errors = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_data = 0;
    s_tdata = 0;
    s_tlast = 0;
    long_hold = 0;
    calm = 0;
    win_reg = 1;
    aonly_reg = 0;
    asum = 0;
    rsum = 0;
    gsum = 0;
    bsum = 0;
    pos = 0;
    head = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    // reset settings: window of one, single-pixel rows and a short row
    push_px(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_px(8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1);
    push_px(8'hFF, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'h80, 8'h55, 8'hAA, 8'h01, 1'b1);
    wait_drained();

    // window 3, extremes, zero-alpha stretch inside the row
    write_reg(awbb_pkg::RegWindowSize, 7'd3);
    push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'h00, 8'h12, 8'h34, 8'h56, 1'b0);
    push_px(8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_px(8'h01, 8'hFF, 8'h00, 8'h7F, 1'b1);
    wait_drained();

    // alpha-only mode
    write_reg(awbb_pkg::RegWindowSize, 7'd4);
    write_reg(awbb_pkg::RegAlphaOnly, 7'd1);
    for (int i = 0; i < 5; i++)
      push_px(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), i == 4);
    wait_drained();
    write_reg(awbb_pkg::RegAlphaOnly, 7'd0);

    // window narrowed in the middle of a row
    write_reg(awbb_pkg::RegWindowSize, 7'd6);
    for (int i = 0; i < 7; i++) push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_drained();
    write_reg(awbb_pkg::RegWindowSize, 7'd2);
    push_px(8'h10, 8'h20, 8'h30, 8'h40, 1'b1);
    wait_drained();

    // out-of-range window values clamp to one and to the maximum
    write_reg(awbb_pkg::RegWindowSize, 7'd0);
    push_px(8'h40, 8'hC0, 8'h80, 8'h20, 1'b1);
    wait_drained();
    write_reg(awbb_pkg::RegWindowSize, 7'h7F);
    push_px(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_px(8'h7F, 8'h01, 8'h80, 8'hFE, 1'b1);
    wait_drained();

    // receiver held off while the sender keeps offering
    write_reg(awbb_pkg::RegWindowSize, 7'd2);
    long_hold <= 1;
    for (int i = 0; i < 14; i++) push_rand_px(i == 13);
    repeat (300) @(posedge clk);
    long_hold <= 0;
    wait_drained();

    sent = 0;
    while (sent < 40) begin
      random_row();
      sent = sent + 6;
    end

    calm <= 1;
    for (int i = 0; i < 3; i++) random_row();

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/awbb_pkg.sv
hw/rtl/awbb_div.sv
hw/rtl/awbb_datapath.sv
hw/rtl/awbb_ctrl.sv
hw/rtl/alpha_weighted_box_blur_row.sv
bench/alpha_weighted_box_blur_row_tb.sv
